// File: design/sbusd_pkg.sv
// Shared types, constants and codes for the SBUS frame decoder.
`default_nettype none

package sbusd_pkg;

  // Fraction bits of the normalized control values
  localparam int NormFracBits = 14;

  localparam int ChW      = 11;
  localparam int NumCh    = 16;
  localparam int ChIdxW   = 4;
  localparam int NumCfg   = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgW     = 4;
  localparam int FrameLen = 25;
  localparam int PosW     = 5;

  // 2^F / 1600 = 2^(F-6) / 25 and 2^F / 800 = 2^(F-5) / 25
  localparam int ThrShift  = NormFracBits - 6;
  localparam int AxisShift = NormFracBits - 5;
  localparam int NumW      = ChW + AxisShift;
  localparam int CntW      = $clog2(NumW);
  localparam int MagW      = NormFracBits + 1;
  localparam int ResW      = 16;
  localparam int WideW     = (MagW + 1 > ResW) ? MagW + 1 : ResW;
  localparam int RemW      = 5;

  localparam logic [RemW:0]   Divisor    = 6'd25;
  localparam logic [7:0]      HeaderByte = 8'h0F;
  localparam logic [7:0]      FooterByte = 8'h00;
  localparam int              FailsafeBit = 3;
  localparam logic [ChW-1:0]  ThrOffset  = 11'd200;
  localparam logic [ChW-1:0]  ThrSpan    = 11'd1600;
  localparam logic [ChW-1:0]  AxisCenter = 11'd1000;
  localparam logic [ChW-1:0]  AxisSpan   = 11'd800;
  localparam logic [ChW-1:0]  ArmLevel   = 11'd1000;
  localparam logic [ChW-1:0]  SwLowLevel = 11'd600;
  localparam logic [ChW-1:0]  SwHighLevel = 11'd1400;

  // Byte positions inside a frame
  localparam logic [PosW-1:0] PosHeader   = 5'd0;
  localparam logic [PosW-1:0] PosLastData = 5'd22;
  localparam logic [PosW-1:0] PosStatus   = 5'd23;
  localparam logic [PosW-1:0] PosFooter   = 5'd24;
  localparam logic [PosW-1:0] PosIdle     = 5'd25;

  // Three-position switch codes
  localparam logic [1:0] SwHigh = 2'd0;
  localparam logic [1:0] SwMid  = 2'd1;
  localparam logic [1:0] SwLow  = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARM          = 3'd0,
    CFG_THROTTLE     = 3'd1,
    CFG_ROLL         = 3'd2,
    CFG_PITCH        = 3'd3,
    CFG_YAW          = 3'd4,
    CFG_RIGHT_POT    = 3'd5,
    CFG_LEFT_POT     = 3'd6,
    CFG_RIGHT_SWITCH = 3'd7
  } cfg_idx_e;

  localparam logic [CfgW-1:0] CfgReset [NumCfg] = '{4'd4, 4'd2, 4'd0, 4'd1,
                                                   4'd3, 4'd6, 4'd7, 4'd5};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_READ,
    ST_EVAL,
    ST_NORM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic               frame_ok;
    logic [2:0]         link_flags;
    logic [7:0]         status_byte;
    logic               armed;
    logic [14:0]        throttle;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] right_pot;
    logic signed [15:0] left_pot;
    logic [1:0]         right_switch;
  } out_word_t;

  // Request into the normalizer
  typedef struct packed {
    logic start;
    logic is_axis;
  } norm_req_t;

endpackage

`default_nettype wire

// File: design/sbusd_norm.sv
// Bit-serial normalizer: channel value to clamped Q value by restoring division by 25.
`default_nettype none

module sbusd_norm (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sbusd_pkg::norm_req_t         req_i,
  input  wire  [sbusd_pkg::ChW-1:0]    ch_i,
  output logic                         done_o,
  output logic [sbusd_pkg::ResW-1:0]   res_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [sbusd_pkg::CntW-1:0]     cnt_q;
  logic [sbusd_pkg::NumW-1:0]     num_q;
  logic [sbusd_pkg::NumW-1:0]     quo_q;
  logic [sbusd_pkg::RemW-1:0]     rem_q;
  logic                           neg_q;
  logic                           sat_q;

  logic [sbusd_pkg::ChW-1:0]      delta;
  logic                           neg;
  logic                           sat;
  logic [sbusd_pkg::NumW-1:0]     num_init;
  logic [sbusd_pkg::RemW:0]       rem_sh;
  logic                           rem_ge;
  logic [sbusd_pkg::MagW-1:0]     mag;
  logic [sbusd_pkg::WideW-1:0]    mag_w;
  logic [sbusd_pkg::WideW-1:0]    res_w;

  // Distance from the range origin, sign and saturation
  always_comb begin
    if (req_i.is_axis) begin
      neg   = (ch_i < sbusd_pkg::AxisCenter);
      delta = neg ? (sbusd_pkg::AxisCenter - ch_i) : (ch_i - sbusd_pkg::AxisCenter);
      sat   = (delta >= sbusd_pkg::AxisSpan);
      num_init = sbusd_pkg::NumW'(delta) << sbusd_pkg::AxisShift;
    end else begin
      neg   = 1'b0;
      delta = (ch_i > sbusd_pkg::ThrOffset) ? (ch_i - sbusd_pkg::ThrOffset) : '0;
      sat   = (delta >= sbusd_pkg::ThrSpan);
      num_init = sbusd_pkg::NumW'(delta) << sbusd_pkg::ThrShift;
    end
  end

  // One quotient bit per cycle
  assign rem_sh = {rem_q, num_q[sbusd_pkg::NumW-1]};
  assign rem_ge = (rem_sh >= sbusd_pkg::Divisor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == sbusd_pkg::CntW'(sbusd_pkg::NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= num_init;
      quo_q <= '0;
      rem_q <= '0;
      neg_q <= neg;
      sat_q <= sat;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[sbusd_pkg::NumW-2:0], rem_ge};
      rem_q <= rem_ge ? sbusd_pkg::RemW'(rem_sh - sbusd_pkg::Divisor)
                      : rem_sh[sbusd_pkg::RemW-1:0];
    end
  end

  // Clamp, apply sign, trim to the field width
  assign mag    = sat_q ? sbusd_pkg::MagW'(1) << sbusd_pkg::NormFracBits
                        : quo_q[sbusd_pkg::MagW-1:0];
  assign mag_w  = sbusd_pkg::WideW'(mag);
  assign res_w  = neg_q ? (~mag_w + 1'b1) : mag_w;
  assign res_o  = res_w[sbusd_pkg::ResW-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: design/sbus_frame_decoder.sv
// SBUS frame decoder top level: byte intake, bit-serial channel unpacking, result sequencing.
// Header, status and out-of-frame bytes are taken straight in the idle state; channel bytes 1..22
// are then shifted one bit per cycle through the channel shift register while byte intake stalls.
// Footer of a good frame: 8 channel-store reads, each followed by an evaluation step, plus 6
// normalizations in the bit-serial normalizer; a rejected frame goes straight to the output step.
// Result appears in an output register; reset clears control, flags and held values and loads the config defaults.
`default_nettype none

module sbus_frame_decoder (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  sbusd_pkg::in_word_t                in_word_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output sbusd_pkg::out_word_t               out_word_o,
  input  wire                                cfg_we_i,
  input  wire  [sbusd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [sbusd_pkg::CfgW-1:0]         cfg_data_i
);

  sbusd_pkg::state_e              state_q, state_d;
  logic [sbusd_pkg::CfgW-1:0]     cfg_q [sbusd_pkg::NumCfg];
  logic [sbusd_pkg::PosW-1:0]     pos_q;
  logic [sbusd_pkg::PosW-1:0]     pos_cur;
  logic [2:0]                     bitcnt_q;
  logic [3:0]                     cbit_q;
  logic [sbusd_pkg::ChIdxW-1:0]   chan_idx_q;
  logic [7:0]                     sh_byte_q;
  logic [sbusd_pkg::ChW-2:0]      chan_sr_q;
  logic [sbusd_pkg::ChW-1:0]      mem [sbusd_pkg::NumCh];
  logic [sbusd_pkg::ChW-1:0]      rd_data_q;
  logic [sbusd_pkg::ChW-1:0]      wr_data;
  logic [sbusd_pkg::CfgIdxW-1:0]  step_q;
  logic                           hdr_good_q;
  logic [7:0]                     status_q;
  logic [1:0]                     sticky_q;
  logic                           ok_q;
  logic                           conn_q;
  sbusd_pkg::out_word_t           held_q;
  sbusd_pkg::out_word_t           out_q;
  sbusd_pkg::out_word_t           out_d;
  logic                           out_vld_q;

  logic                           in_acc;
  logic                           out_acc;
  logic                           in_frame;
  logic                           conn_now;
  logic                           ok_now;
  logic                           mem_we;
  logic                           load_out;
  sbusd_pkg::norm_req_t           norm_req;
  logic                           norm_done;
  logic [sbusd_pkg::ResW-1:0]     norm_res;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_vld_q && !out_stall_i;
  assign pos_cur  = in_word_i.frame_start ? sbusd_pkg::PosHeader : pos_q;
  assign in_frame = (pos_cur < sbusd_pkg::PosIdle);
  assign conn_now = !status_q[sbusd_pkg::FailsafeBit];
  assign ok_now   = hdr_good_q && (in_word_i.byte_value == sbusd_pkg::FooterByte) && conn_now;
  assign wr_data  = {sh_byte_q[0], chan_sr_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbusd_pkg::ST_IDLE: begin
        if (in_acc && in_frame) begin
          if (pos_cur == sbusd_pkg::PosFooter) begin
            state_d = ok_now ? sbusd_pkg::ST_READ : sbusd_pkg::ST_OUT;
          end else if (pos_cur != sbusd_pkg::PosHeader && pos_cur <= sbusd_pkg::PosLastData) begin
            state_d = sbusd_pkg::ST_SHIFT;
          end
        end
      end
      sbusd_pkg::ST_SHIFT: begin
        if (bitcnt_q == 3'd7) state_d = sbusd_pkg::ST_IDLE;
      end
      sbusd_pkg::ST_READ: state_d = sbusd_pkg::ST_EVAL;
      sbusd_pkg::ST_EVAL: begin
        if (step_q == sbusd_pkg::CFG_RIGHT_SWITCH) begin
          state_d = sbusd_pkg::ST_OUT;
        end else if (step_q == sbusd_pkg::CFG_ARM) begin
          state_d = sbusd_pkg::ST_READ;
        end else begin
          state_d = sbusd_pkg::ST_NORM;
        end
      end
      sbusd_pkg::ST_NORM: begin
        if (norm_done) state_d = sbusd_pkg::ST_READ;
      end
      sbusd_pkg::ST_OUT: begin
        if (!out_vld_q || !out_stall_i) state_d = sbusd_pkg::ST_IDLE;
      end
      default: state_d = sbusd_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o       = 1'b1;
    mem_we           = 1'b0;
    load_out         = 1'b0;
    norm_req.start   = 1'b0;
    norm_req.is_axis = (step_q != sbusd_pkg::CFG_THROTTLE);
    case (state_q)
      sbusd_pkg::ST_IDLE:  in_stall_o = 1'b0;
      sbusd_pkg::ST_SHIFT: mem_we = (cbit_q == 4'd10);
      sbusd_pkg::ST_READ:  ;
      sbusd_pkg::ST_EVAL: begin
        norm_req.start = (step_q != sbusd_pkg::CFG_ARM) &&
                         (step_q != sbusd_pkg::CFG_RIGHT_SWITCH);
      end
      sbusd_pkg::ST_NORM:  ;
      sbusd_pkg::ST_OUT:   load_out = !out_vld_q || !out_stall_i;
      default: ;
    endcase
  end

  // Result word: held values with this frame's status bits and the sticky link flags
  always_comb begin
    out_d            = held_q;
    out_d.frame_ok   = ok_q;
    out_d.link_flags = {sticky_q[1], conn_q, sticky_q[0]};
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sbusd_pkg::ST_IDLE;
      pos_q      <= sbusd_pkg::PosIdle;
      bitcnt_q   <= '0;
      cbit_q     <= '0;
      chan_idx_q <= '0;
      step_q     <= '0;
      hdr_good_q <= 1'b0;
      sticky_q   <= '0;
      ok_q       <= 1'b0;
      conn_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      held_q     <= '0;
      for (int i = 0; i < sbusd_pkg::NumCfg; i++) cfg_q[i] <= sbusd_pkg::CfgReset[i];
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;

      // Byte intake; the footer moves the position on to idle
      if (in_acc && in_frame) begin
        pos_q <= pos_cur + 1'b1;
        if (pos_cur == sbusd_pkg::PosHeader) begin
          hdr_good_q <= (in_word_i.byte_value == sbusd_pkg::HeaderByte);
          chan_idx_q <= '0;
          cbit_q     <= '0;
        end
        if (pos_cur == sbusd_pkg::PosFooter) begin
          ok_q     <= ok_now;
          conn_q   <= conn_now;
          sticky_q <= sticky_q | {ok_now, conn_now};
          step_q   <= sbusd_pkg::CFG_ARM;
          if (ok_now) held_q.status_byte <= status_q;
        end
        bitcnt_q <= '0;
      end

      // Bit-serial channel assembly
      if (state_q == sbusd_pkg::ST_SHIFT) begin
        bitcnt_q <= bitcnt_q + 1'b1;
        if (cbit_q == 4'd10) begin
          cbit_q     <= '0;
          chan_idx_q <= chan_idx_q + 1'b1;
        end else begin
          cbit_q <= cbit_q + 1'b1;
        end
      end

      // Result sequencing over the selected channels
      if (state_q == sbusd_pkg::ST_EVAL) begin
        if (step_q == sbusd_pkg::CFG_ARM) begin
          held_q.armed <= (rd_data_q > sbusd_pkg::ArmLevel);
          step_q       <= step_q + 1'b1;
        end else if (step_q == sbusd_pkg::CFG_RIGHT_SWITCH) begin
          held_q.right_switch <= (rd_data_q > sbusd_pkg::SwLowLevel)
              ? ((rd_data_q > sbusd_pkg::SwHighLevel) ? sbusd_pkg::SwHigh : sbusd_pkg::SwMid)
              : sbusd_pkg::SwLow;
        end
      end
      if (state_q == sbusd_pkg::ST_NORM && norm_done) begin
        step_q <= step_q + 1'b1;
        case (step_q)
          sbusd_pkg::CFG_THROTTLE:
            held_q.throttle  <= held_q.armed ? norm_res[14:0] : '0;
          sbusd_pkg::CFG_ROLL:
            held_q.roll      <= held_q.armed ? norm_res : '0;
          sbusd_pkg::CFG_PITCH:
            held_q.pitch     <= held_q.armed ? norm_res : '0;
          sbusd_pkg::CFG_YAW:
            held_q.yaw       <= held_q.armed ? norm_res : '0;
          sbusd_pkg::CFG_RIGHT_POT:
            held_q.right_pot <= held_q.armed ? norm_res : '0;
          sbusd_pkg::CFG_LEFT_POT:
            held_q.left_pot  <= held_q.armed ? norm_res : '0;
          default: ;
        endcase
      end

      // Output register
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && in_frame) begin
      sh_byte_q <= in_word_i.byte_value;
      if (pos_cur == sbusd_pkg::PosStatus) status_q <= in_word_i.byte_value;
    end else if (state_q == sbusd_pkg::ST_SHIFT) begin
      sh_byte_q <= {1'b0, sh_byte_q[7:1]};
      chan_sr_q <= {sh_byte_q[0], chan_sr_q[sbusd_pkg::ChW-2:1]};
    end
    if (load_out) out_q <= out_d;
  end

  // Channel store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[chan_idx_q] <= wr_data;
    rd_data_q <= mem[cfg_q[step_q]];
  end

  sbusd_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .ch_i   (rd_data_q),
    .done_o (norm_done),
    .res_o  (norm_res)
  );

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
